// File: rtl/glc_pkg.sv
`default_nettype none
package glc_pkg;

  localparam int ENTRIES_DEF = 256;
  localparam int CAP_W       = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;
  localparam int STAMP_W     = 64;
  localparam int CNT_W       = 32;

  typedef struct packed {
    logic        cmd;
    logic [20:0] key;
    logic        key_is_glyph;
    logic [11:0] pixel_size;
  } glc_in_t;

  typedef struct packed {
    logic             hit;
    logic [7:0]       slot;
    logic             evicted;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
  } glc_out_t;

  typedef struct packed {
    logic [11:0] pixel_size;
    logic        key_is_glyph;
    logic [20:0] key;
  } glc_tag_t;

  typedef struct packed {
    glc_tag_t           tag;
    logic [STAMP_W-1:0] stamp;
  } glc_entry_t;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_INSERT = 1'b1
  } glc_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } glc_state_t;

endpackage
`default_nettype wire

// File: rtl/glyph_cache_lru_tags_unit.sv
`default_nettype none
// Tag and LRU replacement unit of a fully associative glyph cache. Pulse start
// while busy is low to issue one lookup or insert; exactly one result comes
// back on out_item with a one-cycle out_strobe and cannot be held off, so the
// receiver must take it in that cycle. Tags and use stamps share one memory
// with a single read port, scanned one entry per clock. A lookup searches the
// occupied entries among the active ones (m = min(occupied, capacity)) and
// stops at the first match; an insert into a cache with a free active slot
// needs no scan, otherwise it scans all active entries for the oldest stamp.
// Occupancy is kept as a fill count, so no clearing pass follows reset.
// cfg_ready is always high; write capacity only while idle.
module glyph_cache_lru_tags_unit
  import glc_pkg::*;
#(
  parameter int Entries = ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire glc_in_t          in_item,
  output logic                  out_strobe,
  output glc_out_t              out_item,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_data
);

  localparam int IW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int CW = $clog2(Entries + 1);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] cap_r;
  logic [XW-1:0]    cap_ext;
  logic [CW-1:0]    active_n;

  logic       mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_raddr;
  glc_entry_t mem_wdata;
  glc_entry_t mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // zero or oversize capacity means the full array
  always_comb begin
    cap_ext = XW'(cap_r);
    if (cap_ext == '0 || cap_ext > XW'(Entries)) begin
      active_n = CW'(Entries);
    end else begin
      active_n = cap_ext[CW-1:0];
    end
  end

  glc_ctrl #(
    .Entries (Entries)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .active_n   (active_n),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  glc_tag_ram #(
    .Entries (Entries)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

// File: rtl/glc_tag_ram.sv
`default_nettype none
module glc_tag_ram
  import glc_pkg::*;
#(
  parameter int Entries = ENTRIES_DEF,
  localparam int IW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  wire logic       clk,
  input  wire logic       we,
  input  wire logic [IW-1:0] waddr,
  input  wire glc_entry_t wdata,
  input  wire logic [IW-1:0] raddr,
  output glc_entry_t      rdata
);

  glc_entry_t mem [Entries];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/glc_ctrl.sv
`default_nettype none
module glc_ctrl
  import glc_pkg::*;
#(
  parameter int Entries = ENTRIES_DEF,
  localparam int IW = (Entries > 1) ? $clog2(Entries) : 1,
  localparam int CW = $clog2(Entries + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire glc_in_t       in_item,
  input  wire logic [CW-1:0] active_n,
  output logic               mem_we,
  output logic [IW-1:0]      mem_waddr,
  output glc_entry_t         mem_wdata,
  output logic [IW-1:0]      mem_raddr,
  input  wire glc_entry_t    mem_rdata,
  output logic               out_strobe,
  output glc_out_t           out_item
);

  localparam int SW = (IW > 8) ? IW : 8;

  glc_state_t         state_r, state_nxt;
  glc_cmd_t           cmd_r, cmd_nxt;
  glc_tag_t           tag_r, tag_nxt;
  logic [CW-1:0]      limit_r, limit_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [IW-1:0]      best_idx_r, best_idx_nxt;
  logic [STAMP_W-1:0] best_stamp_r, best_stamp_nxt;
  logic [IW-1:0]      slot_r, slot_nxt;
  logic               hit_r, hit_nxt;
  logic               evict_r, evict_nxt;
  logic [STAMP_W-1:0] tick_r, tick_nxt;
  logic [CNT_W-1:0]   hit_tot_r, hit_tot_nxt;
  logic [CNT_W-1:0]   miss_tot_r, miss_tot_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  glc_out_t           out_r, out_nxt;

  glc_tag_t      in_tag;
  logic [CW-1:0] lookup_limit;
  logic          free_slot;
  logic          issue;
  logic          last_cmp;
  logic          tag_match;
  logic          better;
  logic          do_write;
  logic [SW-1:0] slot_ext;

  always_comb begin
    in_tag.pixel_size   = in_item.pixel_size;
    in_tag.key_is_glyph = in_item.key_is_glyph;
    in_tag.key          = in_item.key;
    lookup_limit = (fill_r < active_n) ? fill_r : active_n;
    free_slot    = fill_r < active_n;
    issue        = idx_r < limit_r;
    last_cmp     = cmp_vld_r && (CW'(cmp_idx_r) == limit_r - CW'(1));
    tag_match    = mem_rdata.tag == tag_r;
    better       = (cmp_idx_r == '0) || (mem_rdata.stamp < best_stamp_r);
    do_write     = (cmd_r == CMD_INSERT) || hit_r;
    slot_ext     = SW'(slot_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_item.cmd == CMD_INSERT) begin
            state_nxt = free_slot ? ST_DONE : ST_SCAN;
          end else begin
            state_nxt = (lookup_limit == '0) ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cmp_vld_r && ((cmd_r == CMD_LOOKUP && tag_match) || last_cmp)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cmd_nxt        = cmd_r;
    tag_nxt        = tag_r;
    limit_nxt      = limit_r;
    idx_nxt        = idx_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    best_idx_nxt   = best_idx_r;
    best_stamp_nxt = best_stamp_r;
    slot_nxt       = slot_r;
    hit_nxt        = hit_r;
    evict_nxt      = evict_r;
    tick_nxt       = tick_r;
    hit_tot_nxt    = hit_tot_r;
    miss_tot_nxt   = miss_tot_r;
    fill_nxt       = fill_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    busy           = state_r != ST_IDLE;
    mem_raddr      = idx_r[IW-1:0];
    mem_we         = 1'b0;
    mem_waddr      = slot_r;
    mem_wdata.tag   = tag_r;
    mem_wdata.stamp = tick_r + STAMP_W'(1);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt   = glc_cmd_t'(in_item.cmd);
          tag_nxt   = in_tag;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          evict_nxt = 1'b0;
          slot_nxt  = '0;
          if (in_item.cmd == CMD_INSERT) begin
            limit_nxt = active_n;
            if (free_slot) begin
              slot_nxt = fill_r[IW-1:0];
            end
          end else begin
            limit_nxt = lookup_limit;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r[IW-1:0];
          idx_nxt     = idx_r + CW'(1);
        end
        if (cmp_vld_r) begin
          if (cmd_r == CMD_LOOKUP) begin
            if (tag_match) begin
              hit_nxt  = 1'b1;
              slot_nxt = cmp_idx_r;
            end
          end else begin
            if (better) begin
              best_idx_nxt   = cmp_idx_r;
              best_stamp_nxt = mem_rdata.stamp;
            end
            if (last_cmp) begin
              slot_nxt  = better ? cmp_idx_r : best_idx_r;
              evict_nxt = 1'b1;
            end
          end
        end
      end
      ST_DONE: begin
        mem_we = do_write;
        if (do_write) begin
          tick_nxt = tick_r + STAMP_W'(1);
        end
        if (cmd_r == CMD_LOOKUP) begin
          if (hit_r) begin
            hit_tot_nxt = hit_tot_r + CNT_W'(1);
          end else begin
            miss_tot_nxt = miss_tot_r + CNT_W'(1);
          end
        end else if (!evict_r) begin
          fill_nxt = fill_r + CW'(1);
        end
        out_strobe_nxt     = 1'b1;
        out_nxt.hit        = hit_r;
        out_nxt.slot       = slot_ext[7:0];
        out_nxt.evicted    = evict_r;
        out_nxt.hit_count  = hit_tot_nxt;
        out_nxt.miss_count = miss_tot_nxt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cmp_vld_r    <= 1'b0;
      tick_r       <= '0;
      hit_tot_r    <= '0;
      miss_tot_r   <= '0;
      fill_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      tick_r       <= tick_nxt;
      hit_tot_r    <= hit_tot_nxt;
      miss_tot_r   <= miss_tot_nxt;
      fill_r       <= fill_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    tag_r        <= tag_nxt;
    limit_r      <= limit_nxt;
    idx_r        <= idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
    slot_r       <= slot_nxt;
    hit_r        <= hit_nxt;
    evict_r      <= evict_nxt;
    out_r        <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule
`default_nettype wire

// File: bench/tb_top.sv
module tb_top;
  import glc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  glc_in_t in_item = '0;
  logic out_strobe;
  glc_out_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  // cache state as the block should hold it
  logic [CAP_W-1:0] capacity_now = CAP_RESET;
  bit occupied [ENTRIES_DEF];
  glc_tag_t tag_mem [ENTRIES_DEF];
  bit [STAMP_W-1:0] stamp_mem [ENTRIES_DEF];
  bit [STAMP_W-1:0] tick_now = '0;
  bit [CNT_W-1:0] hit_tally = '0;
  bit [CNT_W-1:0] miss_tally = '0;

  glc_in_t cache_cmds_pending[$];
  glc_out_t cache_replies_due[$];
  int sender_idle_pct = 0;
  int failures = 0;
  int quiet_cycles = 0;

  glyph_cache_lru_tags_unit #(.Entries(ENTRIES_DEF)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_strobe(out_strobe),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic glc_out_t predict_cache_reply(glc_in_t it);
    glc_tag_t tag;
    glc_out_t r;
    int n;
    int slot;
    int lru;
    bit found;
    tag.key = it.key;
    tag.key_is_glyph = it.key_is_glyph;
    tag.pixel_size = it.pixel_size;
    n = (capacity_now == 0 || capacity_now > ENTRIES_DEF) ? ENTRIES_DEF : capacity_now;
    r = '0;
    slot = 0;
    found = 1'b0;
    if (it.cmd == CMD_LOOKUP) begin
      for (int i = 0; i < n && !found; i++) begin
        if (occupied[i] && tag_mem[i] == tag) begin
          found = 1'b1;
          slot = i;
        end
      end
      if (found) begin
        tick_now++;
        stamp_mem[slot] = tick_now;
        hit_tally++;
        r.hit = 1'b1;
      end else begin
        miss_tally++;
      end
    end else begin
      lru = 0;
      for (int i = 0; i < n && !found; i++) begin
        if (!occupied[i]) begin
          found = 1'b1;
          slot = i;
        end else if (stamp_mem[i] < stamp_mem[lru]) begin
          lru = i;
        end
      end
      if (!found) begin
        slot = lru;
        r.evicted = 1'b1;
      end
      occupied[slot] = 1'b1;
      tag_mem[slot] = tag;
      tick_now++;
      stamp_mem[slot] = tick_now;
    end
    r.slot = slot[7:0];
    r.hit_count = hit_tally;
    r.miss_count = miss_tally;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin : drive_cmds
    logic taken;
    taken = rst_n && start && !busy;
    if (taken) begin
      cache_replies_due.push_back(predict_cache_reply(in_item));
      void'(cache_cmds_pending.pop_front());
    end
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (cache_cmds_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        start <= 1'b1;
        in_item <= cache_cmds_pending[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // monitor
  always @(posedge clk) begin : watch_replies
    glc_out_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (cache_replies_due.size() == 0) begin
        $error("result with no item outstanding");
        failures++;
      end else begin
        want = cache_replies_due.pop_front();
        check_field("hit", 32'(want.hit), 32'(out_item.hit));
        check_field("slot", 32'(want.slot), 32'(out_item.slot));
        check_field("evicted", 32'(want.evicted), 32'(out_item.evicted));
        check_field("hit_count", want.hit_count, out_item.hit_count);
        check_field("miss_count", want.miss_count, out_item.miss_count);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe === 1'b1 || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic glc_tag_t make_tag(logic [20:0] key, logic glyph, logic [11:0] px);
    glc_tag_t t;
    t.key = key;
    t.key_is_glyph = glyph;
    t.pixel_size = px;
    return t;
  endfunction

  function automatic glc_tag_t random_tag();
    return make_tag(21'($urandom), 1'($urandom_range(1)), 12'($urandom));
  endfunction

  task automatic push_cmd(glc_cmd_t c, glc_tag_t t);
    glc_in_t it;
    it.cmd = c;
    it.key = t.key;
    it.key_is_glyph = t.key_is_glyph;
    it.pixel_size = t.pixel_size;
    cache_cmds_pending.push_back(it);
  endtask

  task automatic wait_idle();
    while (!(cache_cmds_pending.size() == 0 && cache_replies_due.size() == 0 &&
             !start && !busy))
      @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    capacity_now = v;
    cfg_valid <= 1'b0;
  endtask

  // mostly lookups on a working set, each followed by an insert half the time, some stray commands
  task automatic fill_random(int count, int set_size);
    glc_tag_t pool[$];
    glc_tag_t t;
    int k;
    for (k = 0; k < set_size; k++) pool.push_back(random_tag());
    k = 0;
    while (k < count) begin
      case ($urandom_range(9))
        0: push_cmd(CMD_LOOKUP, random_tag());
        1: push_cmd(CMD_INSERT, random_tag());
        default: begin
          t = pool[$urandom_range(pool.size() - 1)];
          push_cmd(CMD_LOOKUP, t);
          if ($urandom_range(1)) begin
            push_cmd(CMD_INSERT, t);
            k++;
          end
        end
      endcase
      k++;
    end
  endtask

  initial begin : stimulus
    glc_tag_t ta, tb, tc;
    int caps [11] = '{256, 1, 0, 511, 4, 2, 257, 16, 255, 128, 3};
    int counts [11] = '{150, 80, 100, 90, 120, 80, 60, 120, 100, 60, 40};
    int sets [11] = '{60, 3, 80, 80, 6, 3, 40, 24, 200, 90, 5};
    int idles [11] = '{0, 79, 21, 0, 79, 21, 0, 79, 21, 0, 79};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    ta = make_tag(21'd0, 1'b0, 12'd1);
    tb = make_tag(21'd1114111, 1'b1, 12'd4095);
    tc = make_tag(21'h1FFFFF, 1'b1, 12'd0);
    push_cmd(CMD_LOOKUP, ta);
    push_cmd(CMD_INSERT, ta);
    push_cmd(CMD_LOOKUP, ta);
    push_cmd(CMD_INSERT, tb);
    push_cmd(CMD_LOOKUP, tb);
    push_cmd(CMD_INSERT, tc);
    push_cmd(CMD_LOOKUP, tc);
    push_cmd(CMD_LOOKUP, make_tag(21'd0, 1'b1, 12'd1));
    push_cmd(CMD_LOOKUP, make_tag(21'd0, 1'b0, 12'd2));
    push_cmd(CMD_LOOKUP, make_tag(21'd1114111, 1'b0, 12'd4095));
    push_cmd(CMD_INSERT, ta);
    push_cmd(CMD_LOOKUP, ta);
    push_cmd(CMD_INSERT, make_tag(21'h155555, 1'b0, 12'hAAA));
    push_cmd(CMD_LOOKUP, make_tag(21'h155555, 1'b0, 12'hAAA));
    push_cmd(CMD_LOOKUP, make_tag(21'h0AAAAA, 1'b1, 12'h555));

    for (int p = 0; p < 11; p++) begin
      if (p == 10) caps[p] = $urandom_range(1, 64);
      write_capacity(CAP_W'(caps[p]));
      @(negedge clk);
      sender_idle_pct = idles[p];
      if (p == 1) begin
        // capacity one: every insert evicts slot 0
        push_cmd(CMD_INSERT, tb);
        push_cmd(CMD_LOOKUP, tb);
        push_cmd(CMD_LOOKUP, ta);
      end
      fill_random(counts[p], sets[p]);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
